### rtl/core/mesh_point_rotate_about_center_macros.svh
// assertion macros for the mesh point rotation block
`ifndef MESH_POINT_ROTATE_ABOUT_CENTER_MACROS_SVH
`define MESH_POINT_ROTATE_ABOUT_CENTER_MACROS_SVH

// same-cycle implication
`define MPRAC_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("mprac check failed");

// next-cycle implication
`define MPRAC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("mprac check failed");

`endif

### rtl/core/mprac_pkg.sv
// types, constants and arctangent table for the mesh point rotation block
`timescale 1ns / 1ps

package mprac_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   localparam int COORD_W   = 20;
   localparam int ANGLE_W   = 16;
   localparam int OFFS_W    = COORD_W + 2;
   localparam int CS_W      = 32;
   localparam int Z_W       = 32;
   localparam int FRAC_BITS = 30;
   localparam int PROD_W    = OFFS_W + CS_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int RND_W     = SUM_W - FRAC_BITS;
   localparam int FULL_W    = RND_W + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [OFFS_W-1:0]  offs_type;
   typedef logic signed [CS_W-1:0]    cs_type;
   typedef logic signed [Z_W-1:0]     z_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [RND_W-1:0]   rnd_type;
   typedef logic signed [FULL_W-1:0]  full_type;

   localparam cs_type GAIN_Q30 = cs_type'(652032874);

   localparam z_type ATAN_TABLE [TABLE_LEN] = '{
      z_type'(536870912), z_type'(316933406), z_type'(167458907), z_type'(85004756),
      z_type'(42667331),  z_type'(21354465),  z_type'(10679838),  z_type'(5340245),
      z_type'(2670163),   z_type'(1335087),   z_type'(667544),    z_type'(333772),
      z_type'(166886),    z_type'(83443),     z_type'(41722),     z_type'(20861),
      z_type'(10430),     z_type'(5215),      z_type'(2608),      z_type'(1304),
      z_type'(652),       z_type'(326),       z_type'(163),       z_type'(81)
   };

   typedef struct packed {
      cs_type x;
      cs_type y;
      z_type  z;
   } cordic_type;

   typedef struct packed {
      offs_type  u;
      offs_type  v;
      coord_type cx;
      coord_type cy;
      logic      last;
   } side_type;

endpackage

### rtl/core/mprac_cordic.sv
// pipelined rotation-mode cordic, one stage per register, side data carried along
`timescale 1ns / 1ps

module mprac_cordic import mprac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  cordic_type in_data,
   input  side_type   in_side,
   output logic       out_valid,
   output cordic_type out_data,
   output side_type   out_side
);

   logic       valid_link [NUM_STAGES+1];
   cordic_type data_link  [NUM_STAGES+1];
   side_type   side_link  [NUM_STAGES+1];

   assign valid_link[0] = in_valid;
   assign data_link[0]  = in_data;
   assign side_link[0]  = in_side;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      cordic_type cur;
      cordic_type data_in;
      cordic_type data_ff;
      side_type   side_ff;
      logic       valid_ff;
      cs_type     xs;
      cs_type     ys;

      assign cur = data_link[i];
      assign xs  = cur.x >>> i;
      assign ys  = cur.y >>> i;

      always_comb begin
         if (!cur.z[Z_W-1]) begin
            data_in.x = cur.x - ys;
            data_in.y = cur.y + xs;
            data_in.z = cur.z - ATAN_TABLE[i];
         end else begin
            data_in.x = cur.x + ys;
            data_in.y = cur.y - xs;
            data_in.z = cur.z + ATAN_TABLE[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= valid_link[i];
         end
      end

      always_ff @(posedge clock) begin
         data_ff <= data_in;
         side_ff <= side_link[i];
      end

      assign valid_link[i+1] = valid_ff;
      assign data_link[i+1]  = data_ff;
      assign side_link[i+1]  = side_ff;
   end

   assign out_valid = valid_link[NUM_STAGES];
   assign out_data  = data_link[NUM_STAGES];
   assign out_side  = side_link[NUM_STAGES];

endmodule

### rtl/core/mesh_point_rotate_about_center.sv
// mesh point rotation about a center: fold, cordic, multiply, round, saturate
// register path from the start transfer to the rsp_valid strobe: input fold, one register per
// cordic stage, multiply, round, sum
// throughput: one point per cycle, busy stays low; the cordic pipeline sets the depth
// reset: synchronous, active high, clears all valid bits; nothing is pending after it
`timescale 1ns / 1ps

`include "mesh_point_rotate_about_center_macros.svh"

module mesh_point_rotate_about_center import mprac_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_x_in,
   input  logic signed [COORD_W-1:0] req_y_in,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [ANGLE_W-1:0]        req_turn_angle,
   input  logic                      req_last_point,
   output logic                      rsp_valid,
   output logic signed [COORD_W-1:0] rsp_x_out,
   output logic signed [COORD_W-1:0] rsp_y_out,
   output logic                      rsp_last_out
);

   function automatic coord_type sat_coord(input full_type v);
      full_type hi;
      full_type lo;
      hi = full_type'(coord_type'({1'b0, {(COORD_W-1){1'b1}}}));
      lo = full_type'(coord_type'({1'b1, {(COORD_W-1){1'b0}}}));
      if (v > hi) begin
         return coord_type'(hi);
      end else if (v < lo) begin
         return coord_type'(lo);
      end else begin
         return coord_type'(v);
      end
   endfunction

   // input fold
   logic                      flip;
   logic signed [ANGLE_W-1:0] folded;
   offs_type                  px, py, pcx, pcy;
   cordic_type                in_data_in, in_data_ff;
   side_type                  in_side_in, in_side_ff;
   logic                      in_valid_ff;

   // cordic outputs
   logic       cor_valid;
   cordic_type cor_data;
   side_type   cor_side;

   // multiply stage
   prod_type   p_uc_in, p_vs_in, p_us_in, p_vc_in;
   prod_type   p_uc_ff, p_vs_ff, p_us_ff, p_vc_ff;
   side_type   mul_side_ff;
   logic       mul_valid_ff;

   // round stage
   logic signed [SUM_W-1:0] sum_x, sum_y;
   rnd_type                 rx_in, ry_in, rx_ff, ry_ff;
   side_type                sum_side_ff;
   logic                    sum_valid_ff;

   // output stage
   full_type  fx, fy;
   coord_type rsp_x_in, rsp_y_in;
   coord_type rsp_x_ff, rsp_y_ff;
   logic      rsp_last_ff;
   logic      rsp_valid_ff;

   localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

   assign busy = 1'b0;

   assign flip   = req_turn_angle[ANGLE_W-1] ^ req_turn_angle[ANGLE_W-2];
   assign folded = {req_turn_angle[ANGLE_W-1] ^ flip, req_turn_angle[ANGLE_W-2:0]};
   assign px     = offs_type'(req_x_in);
   assign py     = offs_type'(req_y_in);
   assign pcx    = offs_type'(req_center_x);
   assign pcy    = offs_type'(req_center_y);

   always_comb begin
      in_data_in.x    = GAIN_Q30;
      in_data_in.y    = '0;
      in_data_in.z    = {folded, {(Z_W-ANGLE_W){1'b0}}};
      in_side_in.u    = flip ? (pcx - px) : (px - pcx);
      in_side_in.v    = flip ? (pcy - py) : (py - pcy);
      in_side_in.cx   = req_center_x;
      in_side_in.cy   = req_center_y;
      in_side_in.last = req_last_point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_side_ff <= in_side_in;
   end

   mprac_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_data   (in_data_ff),
      .in_side   (in_side_ff),
      .out_valid (cor_valid),
      .out_data  (cor_data),
      .out_side  (cor_side)
   );

   assign p_uc_in = prod_type'(cor_side.u) * prod_type'(cor_data.x);
   assign p_vs_in = prod_type'(cor_side.v) * prod_type'(cor_data.y);
   assign p_us_in = prod_type'(cor_side.u) * prod_type'(cor_data.y);
   assign p_vc_in = prod_type'(cor_side.v) * prod_type'(cor_data.x);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= cor_valid;
      end
   end

   always_ff @(posedge clock) begin
      p_uc_ff     <= p_uc_in;
      p_vs_ff     <= p_vs_in;
      p_us_ff     <= p_us_in;
      p_vc_ff     <= p_vc_in;
      mul_side_ff <= cor_side;
   end

   assign sum_x = (SUM_W)'(p_uc_ff) - (SUM_W)'(p_vs_ff) + HALF;
   assign sum_y = (SUM_W)'(p_us_ff) + (SUM_W)'(p_vc_ff) + HALF;
   assign rx_in = sum_x[SUM_W-1:FRAC_BITS];
   assign ry_in = sum_y[SUM_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      sum_side_ff <= mul_side_ff;
   end

   assign fx       = full_type'(rx_ff) + full_type'(sum_side_ff.cx);
   assign fy       = full_type'(ry_ff) + full_type'(sum_side_ff.cy);
   assign rsp_x_in = sat_coord(fx);
   assign rsp_y_in = sat_coord(fy);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= sum_side_ff.last;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_x_out    = rsp_x_ff;
   assign rsp_y_out    = rsp_y_ff;
   assign rsp_last_out = rsp_last_ff;

   `MPRAC_ASSERT_NEXT(a_transfer_enters, clock, reset, start && !busy, in_valid_ff)
   `MPRAC_ASSERT_NEXT(a_round_to_out, clock, reset, sum_valid_ff,
                      rsp_valid_ff && (rsp_last_ff == $past(sum_side_ff.last)))
   `MPRAC_ASSERT_NOW(a_out_from_round, clock, reset, rsp_valid_ff, $past(sum_valid_ff))
   `MPRAC_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset,
                      !rsp_valid_ff && !mul_valid_ff && !in_valid_ff)

endmodule

### tb/mesh_point_rotate_about_center_checker.sv
// checker for the mesh point rotation: watches both channels, predicts each point and compares
`timescale 1ns / 1ps

module mesh_point_rotate_about_center_checker import mprac_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  coord_type          req_x_in,
   input  coord_type          req_y_in,
   input  coord_type          req_center_x,
   input  coord_type          req_center_y,
   input  logic [ANGLE_W-1:0] req_turn_angle,
   input  logic               req_last_point,
   input  logic               rsp_valid,
   input  coord_type          rsp_x_out,
   input  coord_type          rsp_y_out,
   input  logic               rsp_last_out,
   output int                 error_count,
   output int                 pending_count,
   output int                 point_count,
   output int                 last_count
);

   localparam int     MAX_STAGES    = 24;
   localparam int     ACTIVE_STAGES = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam longint QUARTER_TURN  = 16384;
   localparam longint HALF_TURN     = 32768;
   localparam longint THREE_QUARTER = 49152;
   localparam longint FULL_TURN     = 65536;
   localparam longint UNIT_GAIN     = 652032874;
   localparam int     PRODUCT_FRAC  = 30;
   localparam longint COORD_HIGH    = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint COORD_LOW     = -(longint'(1) << (COORD_W - 1));

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } rotated_point_type;

   longint arctan_turns [MAX_STAGES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   rotated_point_type expected_points [$];
   rotated_point_type want;

   function automatic rotated_point_type rotate_point(coord_type px, coord_type py,
                                                      coord_type cx, coord_type cy,
                                                      logic [ANGLE_W-1:0] angle,
                                                      logic lst);
      longint            a;
      longint            cosv;
      longint            sinv;
      longint            zacc;
      longint            xs;
      longint            ys;
      longint            u;
      longint            v;
      longint            rx;
      longint            ry;
      bit                flip;
      rotated_point_type r;
      a = angle;
      flip = 1'b0;
      if (a >= QUARTER_TURN && a < THREE_QUARTER) begin
         a = a - HALF_TURN;
         flip = 1'b1;
      end else if (a >= THREE_QUARTER) begin
         a = a - FULL_TURN;
      end
      cosv = UNIT_GAIN;
      sinv = 0;
      zacc = a * 65536;
      for (int i = 0; i < ACTIVE_STAGES; i++) begin
         xs = cosv >>> i;
         ys = sinv >>> i;
         if (zacc >= 0) begin
            cosv = cosv - ys;
            sinv = sinv + xs;
            zacc = zacc - arctan_turns[i];
         end else begin
            cosv = cosv + ys;
            sinv = sinv - xs;
            zacc = zacc + arctan_turns[i];
         end
      end
      if (flip) begin
         cosv = -cosv;
         sinv = -sinv;
      end
      u = longint'(px) - longint'(cx);
      v = longint'(py) - longint'(cy);
      rx = ((u * cosv - v * sinv + (longint'(1) << (PRODUCT_FRAC - 1))) >>> PRODUCT_FRAC)
           + longint'(cx);
      ry = ((u * sinv + v * cosv + (longint'(1) << (PRODUCT_FRAC - 1))) >>> PRODUCT_FRAC)
           + longint'(cy);
      if (rx > COORD_HIGH) rx = COORD_HIGH;
      if (rx < COORD_LOW) rx = COORD_LOW;
      if (ry > COORD_HIGH) ry = COORD_HIGH;
      if (ry < COORD_LOW) ry = COORD_LOW;
      r.x = coord_type'(rx);
      r.y = coord_type'(ry);
      r.last = lst;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_points.delete();
         error_count = 0;
         point_count = 0;
         last_count = 0;
      end else begin
         if (start && !busy) begin
            expected_points.push_back(rotate_point(req_x_in, req_y_in, req_center_x,
                                                   req_center_y, req_turn_angle, req_last_point));
            point_count++;
            if (req_last_point) last_count++;
         end
         if (rsp_valid) begin
            if (expected_points.size() == 0) begin
               $error("result with nothing expected: x_out %0d y_out %0d last_out %0b",
                      rsp_x_out, rsp_y_out, rsp_last_out);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_x_out !== want.x) begin
                  $error("x_out mismatch: expected %0d, actual %0d", want.x, rsp_x_out);
                  error_count++;
               end
               if (rsp_y_out !== want.y) begin
                  $error("y_out mismatch: expected %0d, actual %0d", want.y, rsp_y_out);
                  error_count++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out mismatch: expected %0b, actual %0b", want.last, rsp_last_out);
                  error_count++;
               end
            end
         end
      end
      pending_count = expected_points.size();
   end

endmodule

### tb/mesh_point_rotate_about_center_test.sv
// testbench top for the mesh point rotation: clock, reset, point stimulus and verdict
`timescale 1ns / 1ps

module mesh_point_rotate_about_center_test;
   import mprac_pkg::*;

   localparam int        RANDOM_POINTS = 1530;
   localparam int        CYCLE_LIMIT   = 400000;
   localparam int        DRAIN_CYCLES  = CORDIC_STAGES + 12;
   localparam coord_type COORD_TOP     = coord_type'((1 << (COORD_W - 1)) - 1);
   localparam coord_type COORD_BOTTOM  = coord_type'(1 << (COORD_W - 1));
   localparam coord_type ONE           = coord_type'(65536);
   localparam coord_type HALF          = coord_type'(32768);

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   coord_type          req_x_in;
   coord_type          req_y_in;
   coord_type          req_center_x;
   coord_type          req_center_y;
   logic [ANGLE_W-1:0] req_turn_angle;
   logic               req_last_point;
   logic               rsp_valid;
   coord_type          rsp_x_out;
   coord_type          rsp_y_out;
   logic               rsp_last_out;
   int                 error_count;
   int                 pending_count;
   int                 point_count;
   int                 last_count;
   int                 cycle_count;

   mesh_point_rotate_about_center DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_in       (req_x_in),
      .req_y_in       (req_y_in),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_turn_angle (req_turn_angle),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_x_out      (rsp_x_out),
      .rsp_y_out      (rsp_y_out),
      .rsp_last_out   (rsp_last_out)
   );

   mesh_point_rotate_about_center_checker rotation_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_in       (req_x_in),
      .req_y_in       (req_y_in),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_turn_angle (req_turn_angle),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_x_out      (rsp_x_out),
      .rsp_y_out      (rsp_y_out),
      .rsp_last_out   (rsp_last_out),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .point_count    (point_count),
      .last_count     (last_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** mesh_point_rotate_about_center: FAILED **");
      $finish;
   end

   task automatic send_point(input coord_type px, input coord_type py, input coord_type cx,
                             input coord_type cy, input logic [ANGLE_W-1:0] ang,
                             input logic lst);
      @(negedge clock);
      start <= 1'b1;
      req_x_in <= px;
      req_y_in <= py;
      req_center_x <= cx;
      req_center_y <= cy;
      req_turn_angle <= ang;
      req_last_point <= lst;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain_points();
      hold_off(1);
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic coord_type near_coord();
      return coord_type'(int'($urandom_range(0, 262143)) - 131072);
   endfunction

   function automatic logic [ANGLE_W-1:0] pick_angle();
      logic [ANGLE_W-1:0] fold_edge;
      case ($urandom_range(3))
         0: fold_edge = 16'd0;
         1: fold_edge = 16'd16384;
         2: fold_edge = 16'd32768;
         default: fold_edge = 16'd49152;
      endcase
      if ($urandom_range(3) == 0)
         return fold_edge + ANGLE_W'(int'($urandom_range(0, 8)) - 4);
      return ANGLE_W'($urandom());
   endfunction

   initial begin
      int                 sent;
      int                 pass_len;
      int                 r;
      bit                 wide;
      bit                 steady;
      bit                 pressure_done;
      coord_type          cx;
      coord_type          cy;
      coord_type          px;
      coord_type          py;
      logic [ANGLE_W-1:0] ang;
      logic               lst;

      reset = 1'b1;
      start = 1'b0;
      req_x_in = '0;
      req_y_in = '0;
      req_center_x = '0;
      req_center_y = '0;
      req_turn_angle = '0;
      req_last_point = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // quadrant folds and exact quarter turns
      send_point('0, '0, '0, '0, 16'd0, 1'b0);
      send_point(ONE, '0, '0, '0, 16'd16384, 1'b0);
      send_point(ONE, HALF, '0, '0, 16'd0, 1'b0);
      send_point(ONE, HALF, '0, '0, 16'd16383, 1'b0);
      send_point(ONE, HALF, '0, '0, 16'd32767, 1'b1);
      send_point(ONE, HALF, '0, '0, 16'd32768, 1'b0);
      send_point(ONE, HALF, '0, '0, 16'd49151, 1'b0);
      send_point(ONE, HALF, '0, '0, 16'd49152, 1'b0);
      send_point(ONE, HALF, '0, '0, 16'd65535, 1'b1);
      send_point(ONE, HALF, HALF, -ONE, 16'd8192, 1'b0);
      hold_off(3);
      // coordinate extremes and saturation both ways
      send_point(COORD_TOP, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, 16'd0, 1'b0);
      send_point(COORD_TOP, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, 16'd32768, 1'b1);
      send_point(COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, COORD_TOP, 16'd0, 1'b0);
      send_point(COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, COORD_TOP, 16'd32768, 1'b0);
      send_point(COORD_TOP, COORD_TOP, '0, '0, 16'd8192, 1'b0);
      send_point(COORD_BOTTOM, COORD_BOTTOM, '0, '0, 16'd8192, 1'b1);
      send_point(COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, 16'd16384, 1'b0);
      send_point(COORD_BOTTOM, COORD_TOP, COORD_TOP, COORD_BOTTOM, 16'd49152, 1'b0);
      send_point(COORD_TOP, '0, COORD_TOP, '0, 16'd65535, 1'b0);
      send_point(coord_type'(20'h55555), coord_type'(20'hAAAAA), coord_type'(20'hAAAAA),
                 coord_type'(20'h55555), 16'hAAAA, 1'b1);
      send_point(coord_type'(20'hAAAAA), coord_type'(20'h55555), coord_type'(20'h55555),
                 coord_type'(20'hAAAAA), 16'h5555, 1'b0);
      drain_points();

      // random mesh passes: shared center and angle per pass, last flag on the final point
      sent = 0;
      pressure_done = 1'b0;
      while (sent < RANDOM_POINTS) begin
         pass_len = $urandom_range(1, 24);
         wide = ($urandom_range(3) == 0);
         steady = ($urandom_range(3) == 0);
         cx = wide ? coord_type'($urandom()) : near_coord();
         cy = wide ? coord_type'($urandom()) : near_coord();
         ang = pick_angle();
         for (int k = 0; k < pass_len; k++) begin
            px = wide ? coord_type'($urandom()) : near_coord();
            py = wide ? coord_type'($urandom()) : near_coord();
            lst = (k == pass_len - 1);
            // noise: stray flags and points with their own center and angle
            if ($urandom_range(19) == 0) begin
               lst = 1'($urandom_range(1));
               send_point(px, py, coord_type'($urandom()), coord_type'($urandom()),
                          ANGLE_W'($urandom()), lst);
            end else begin
               send_point(px, py, cx, cy, ang, lst);
            end
            sent++;
            if (!steady) begin
               r = $urandom_range(99);
               if (r >= 93) hold_off($urandom_range(8, 40));
               else if (r >= 65) hold_off($urandom_range(1, 3));
            end
         end
         if (!pressure_done && sent >= RANDOM_POINTS / 2) begin
            drain_points();
            pressure_done = 1'b1;
         end
      end

      drain_points();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d points (%0d with the last flag) across all angle folds,",
               point_count, last_count);
      $display("coordinate extremes, saturation and back-to-back and gapped transfers");
      if (error_count == 0) begin
         $display("** mesh_point_rotate_about_center: PASSED **");
      end else begin
         $display("** mesh_point_rotate_about_center: FAILED **");
      end
      $finish;
   end

endmodule
